// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// shared types, codes and helpers of the raster line compressor
// ----------------------------------------------------------------------------
`default_nettype none

package rlc_pkg;

    // default run limits
    localparam int DEF_MAX_PACK_RUN = 127;
    localparam int DEF_MAX_RLE_RUN  = 256;

    // base of the packbits repeat header
    localparam logic [8:0] PACK_HDR_BASE = 9'd257;

    // compression mode register codes
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_RLE  = 2'd1,
        MODE_PACK = 2'd2,
        MODE_RAW  = 2'd3
    } mode_t;

    // encoder phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HELD = 2'd1,
        PH_REP  = 2'd2,
        PH_LIT  = 2'd3
    } enc_phase_t;

    // byte sequencer state
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_HDR  = 2'd1,
        SEQ_LIT  = 2'd2,
        SEQ_TAIL = 2'd3
    } seq_state_t;

    // one byte of the compressed stream with its framing marks
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eol;
    } rlc_byte_t;

    // packbits repeat header for a run of the given length
    function automatic logic [7:0] pack_rep_hdr(input logic [8:0] run);
        logic [8:0] diff;
        diff = PACK_HDR_BASE - run;
        return diff[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/rlc_lit_mem.sv =====
// ----------------------------------------------------------------------------
// rlc_lit_mem
// literal byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_lit_mem #(
    parameter int DEPTH = 127,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/rlc_encoder.sv =====
// ----------------------------------------------------------------------------
// rlc_encoder
// run / literal encoder state and the byte sequencer that emits one compressed
// byte per ready cycle, reading pending literals from the store
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_encoder #(
    parameter int MAX_PACK_RUN = rlc_pkg::DEF_MAX_PACK_RUN,
    parameter int MAX_RLE_RUN  = rlc_pkg::DEF_MAX_RLE_RUN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rlc_pkg::mode_t    mode,
    input  wire logic              clear,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_line,
    output logic                   byte_valid,
    input  wire logic              byte_ready,
    output rlc_pkg::rlc_byte_t     byte_out
);

    import rlc_pkg::*;

    localparam int AW  = $clog2(MAX_PACK_RUN);
    localparam int CW  = $clog2(MAX_PACK_RUN + 1);
    localparam int RWR = $clog2(MAX_RLE_RUN + 1);
    localparam int RW  = (RWR > CW) ? RWR : CW;

    // encoder state
    logic [7:0]    held_reg, held_next;
    logic [RW-1:0] run_reg, run_next;
    enc_phase_t    phase_reg, phase_next;
    logic [CW-1:0] lit_cnt_reg, lit_cnt_next;

    // sequencer state
    seq_state_t    state_reg, state_next;
    logic [CW-1:0] flush_cnt_reg;
    logic [7:0]    tail_reg [4];
    logic [2:0]    tail_len_reg;
    logic [1:0]    tail_idx_reg;
    logic [AW-1:0] idx_reg;
    logic          eol_reg;
    logic          pend_reg;
    logic [7:0]    pend_data_reg;

    // plan of the accepted item
    logic          in_xfer;
    logic          same_byte;
    logic          wr_now_en;
    logic [AW-1:0] wr_now_addr;
    logic          flush_en;
    logic [CW-1:0] flush_cnt;
    logic [7:0]    tail_b [4];
    logic [2:0]    tail_len;
    logic          pend_set;

    // memory and sequencer controls
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;
    logic          lit_last;
    logic          tail_last;
    logic          byte_xfer;
    logic [7:0]    hdr_byte;

    assign in_xfer   = in_valid && in_ready;
    assign byte_xfer = byte_valid && byte_ready;
    assign same_byte = (data_byte == held_reg);
    assign hdr_byte  = 8'(flush_cnt_reg - CW'(1));
    assign lit_last  = (idx_reg == AW'(flush_cnt_reg - CW'(1)));
    assign tail_last = ({1'b0, tail_idx_reg} == (tail_len_reg - 3'd1));

    // encoding decision for the byte on the input
    always_comb
    begin
        held_next    = held_reg;
        run_next     = run_reg;
        phase_next   = phase_reg;
        lit_cnt_next = lit_cnt_reg;
        wr_now_en    = 1'b0;
        wr_now_addr  = '0;
        flush_en     = 1'b0;
        flush_cnt    = lit_cnt_reg;
        tail_b[0]    = 8'd0;
        tail_b[1]    = 8'd0;
        tail_b[2]    = 8'd0;
        tail_b[3]    = 8'd0;
        tail_len     = 3'd0;
        pend_set     = 1'b0;

        unique case (mode)
            MODE_RLE:
            begin
                if (phase_reg == PH_REP && same_byte && run_reg < RW'(MAX_RLE_RUN))
                begin
                    run_next = run_reg + RW'(1);
                    if (end_of_line)
                    begin
                        tail_b[0] = 8'(run_reg);
                        tail_b[1] = held_reg;
                        tail_len  = 3'd2;
                    end
                end
                else
                begin
                    held_next  = data_byte;
                    run_next   = RW'(1);
                    phase_next = PH_REP;
                    if (phase_reg == PH_REP)
                    begin
                        tail_b[0] = 8'(run_reg - RW'(1));
                        tail_b[1] = held_reg;
                        tail_b[3] = data_byte;
                        tail_len  = end_of_line ? 3'd4 : 3'd2;
                    end
                    else if (end_of_line)
                    begin
                        tail_b[1] = data_byte;
                        tail_len  = 3'd2;
                    end
                end
            end

            MODE_PACK:
            begin
                unique case (phase_reg)
                    PH_HELD:
                    begin
                        if (same_byte)
                        begin
                            run_next   = RW'(2);
                            phase_next = PH_REP;
                            tail_b[0]  = pack_rep_hdr(9'd2);
                            tail_b[1]  = held_reg;
                            tail_len   = end_of_line ? 3'd2 : 3'd0;
                        end
                        else
                        begin
                            wr_now_en    = 1'b1;
                            lit_cnt_next = CW'(1);
                            held_next    = data_byte;
                            phase_next   = PH_LIT;
                            tail_b[1]    = held_reg;
                            tail_b[3]    = data_byte;
                            tail_len     = end_of_line ? 3'd4 : 3'd0;
                        end
                    end

                    PH_REP:
                    begin
                        if (same_byte && run_reg < RW'(MAX_PACK_RUN))
                        begin
                            run_next  = run_reg + RW'(1);
                            tail_b[0] = pack_rep_hdr(9'(run_reg) + 9'd1);
                            tail_b[1] = held_reg;
                            tail_len  = end_of_line ? 3'd2 : 3'd0;
                        end
                        else
                        begin
                            held_next  = data_byte;
                            phase_next = PH_HELD;
                            tail_b[0]  = pack_rep_hdr(9'(run_reg));
                            tail_b[1]  = held_reg;
                            tail_b[3]  = data_byte;
                            tail_len   = end_of_line ? 3'd4 : 3'd2;
                        end
                    end

                    PH_LIT:
                    begin
                        if (!same_byte && lit_cnt_reg < CW'(MAX_PACK_RUN))
                        begin
                            // extend the literal
                            wr_now_en    = 1'b1;
                            wr_now_addr  = AW'(lit_cnt_reg);
                            lit_cnt_next = lit_cnt_reg + CW'(1);
                            held_next    = data_byte;
                            flush_en     = end_of_line;
                            flush_cnt    = lit_cnt_reg + CW'(1);
                            tail_b[1]    = data_byte;
                            tail_len     = end_of_line ? 3'd2 : 3'd0;
                        end
                        else
                        begin
                            // close the literal, then restart from the held byte
                            flush_en  = (lit_cnt_reg != '0);
                            flush_cnt = lit_cnt_reg;
                            if (same_byte)
                            begin
                                lit_cnt_next = '0;
                                run_next     = RW'(2);
                                phase_next   = PH_REP;
                                tail_b[0]    = pack_rep_hdr(9'd2);
                                tail_b[1]    = held_reg;
                                tail_len     = end_of_line ? 3'd2 : 3'd0;
                            end
                            else
                            begin
                                pend_set     = !end_of_line;
                                lit_cnt_next = CW'(1);
                                held_next    = data_byte;
                                tail_b[1]    = held_reg;
                                tail_b[3]    = data_byte;
                                tail_len     = end_of_line ? 3'd4 : 3'd0;
                            end
                        end
                    end

                    PH_IDLE:
                    begin
                        held_next  = data_byte;
                        phase_next = PH_HELD;
                        tail_b[1]  = data_byte;
                        tail_len   = end_of_line ? 3'd2 : 3'd0;
                    end
                endcase
            end

            MODE_NONE, MODE_RAW:
            begin
                tail_b[0] = data_byte;
                tail_len  = 3'd1;
            end
        endcase

        // every line is encoded on its own
        if (end_of_line && (mode == MODE_RLE || mode == MODE_PACK))
        begin
            held_next    = 8'd0;
            run_next     = '0;
            phase_next   = PH_IDLE;
            lit_cnt_next = '0;
        end
    end

    // encoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 8'd0;
            run_reg     <= '0;
            phase_reg   <= PH_IDLE;
            lit_cnt_reg <= '0;
        end
        else if (clear)
        begin
            held_reg    <= 8'd0;
            run_reg     <= '0;
            phase_reg   <= PH_IDLE;
            lit_cnt_reg <= '0;
        end
        else if (in_xfer)
        begin
            held_reg    <= held_next;
            run_reg     <= run_next;
            phase_reg   <= phase_next;
            lit_cnt_reg <= lit_cnt_next;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_xfer)
                begin
                    if (flush_en)
                    begin
                        state_next = SEQ_HDR;
                    end
                    else if (tail_len != 3'd0)
                    begin
                        state_next = SEQ_TAIL;
                    end
                end
            end
            SEQ_HDR:
            begin
                if (byte_ready)
                begin
                    state_next = SEQ_LIT;
                end
            end
            SEQ_LIT:
            begin
                if (byte_ready && lit_last)
                begin
                    state_next = (tail_len_reg != 3'd0) ? SEQ_TAIL : SEQ_IDLE;
                end
            end
            SEQ_TAIL:
            begin
                if (byte_ready && tail_last)
                begin
                    state_next = SEQ_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready      = 1'b0;
        byte_valid    = 1'b0;
        byte_out.data = 8'd0;
        byte_out.last = 1'b0;
        byte_out.eol  = eol_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = wr_now_addr;
        mem_wr_data   = held_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready  = 1'b1;
                mem_wr_en = in_valid && wr_now_en;
            end
            SEQ_HDR:
            begin
                byte_valid    = 1'b1;
                byte_out.data = hdr_byte;
                mem_rd_en     = byte_ready;
            end
            SEQ_LIT:
            begin
                byte_valid    = 1'b1;
                byte_out.data = mem_rd_data;
                byte_out.last = lit_last && (tail_len_reg == 3'd0);
                mem_rd_en     = byte_ready && !lit_last;
                mem_rd_addr   = idx_reg + AW'(1);
                // first literal entry is already read, safe to reuse it
                mem_wr_en     = pend_reg;
                mem_wr_addr   = '0;
                mem_wr_data   = pend_data_reg;
            end
            SEQ_TAIL:
            begin
                byte_valid    = 1'b1;
                byte_out.data = tail_reg[tail_idx_reg];
                byte_out.last = tail_last;
            end
        endcase
    end

    // sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEQ_IDLE;
            tail_len_reg <= 3'd0;
            tail_idx_reg <= 2'd0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                tail_len_reg <= tail_len;
                tail_idx_reg <= 2'd0;
                idx_reg      <= '0;
                pend_reg     <= pend_set;
            end
            else
            begin
                if (state_reg == SEQ_LIT)
                begin
                    pend_reg <= 1'b0;
                    if (byte_xfer && !lit_last)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                if (state_reg == SEQ_TAIL && byte_xfer)
                begin
                    tail_idx_reg <= tail_idx_reg + 2'd1;
                end
            end
        end
    end

    // per-item payload captured at the input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            flush_cnt_reg <= flush_cnt;
            eol_reg       <= end_of_line;
            pend_data_reg <= held_reg;
            tail_reg[0]   <= tail_b[0];
            tail_reg[1]   <= tail_b[1];
            tail_reg[2]   <= tail_b[2];
            tail_reg[3]   <= tail_b[3];
        end
    end

    rlc_lit_mem #(
        .DEPTH (MAX_PACK_RUN),
        .AW    (AW)
    ) u_lit_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ===== src/rlc_packer.sv =====
// ----------------------------------------------------------------------------
// rlc_packer
// gathers the byte stream into results of up to four bytes and holds
// each result in an output register until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_packer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire rlc_pkg::rlc_byte_t byte_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte_a,
    output logic [7:0]              out_byte_b,
    output logic [7:0]              out_byte_c,
    output logic [7:0]              out_byte_d,
    output logic [2:0]              byte_count,
    output logic                    run_last,
    output logic                    line_last
);

    import rlc_pkg::*;

    logic [7:0] acc_reg [3];
    logic [1:0] acc_cnt_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg [4];
    logic [2:0] cnt_reg;
    logic       run_last_reg;
    logic       line_last_reg;

    logic       byte_xfer;
    logic       close_res;
    logic [7:0] pos [4];

    assign byte_ready = !out_valid_reg || out_ready;
    assign byte_xfer  = byte_valid && byte_ready;
    assign close_res  = byte_xfer && (acc_cnt_reg == 2'd3 || byte_in.last);

    // place the incoming byte after the gathered ones, zero the rest
    always_comb
    begin
        pos[0] = (acc_cnt_reg == 2'd0) ? byte_in.data : acc_reg[0];
        pos[1] = (acc_cnt_reg == 2'd1) ? byte_in.data :
                 (acc_cnt_reg >  2'd1) ? acc_reg[1] : 8'd0;
        pos[2] = (acc_cnt_reg == 2'd2) ? byte_in.data :
                 (acc_cnt_reg == 2'd3) ? acc_reg[2] : 8'd0;
        pos[3] = (acc_cnt_reg == 2'd3) ? byte_in.data : 8'd0;
    end

    // gather count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (close_res)
            begin
                acc_cnt_reg <= 2'd0;
            end
            else if (byte_xfer)
            begin
                acc_cnt_reg <= acc_cnt_reg + 2'd1;
            end

            if (close_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // gathered bytes and the result register
    always_ff @(posedge clk)
    begin
        if (byte_xfer && !close_res)
        begin
            acc_reg[acc_cnt_reg] <= byte_in.data;
        end
        if (close_res)
        begin
            out_data_reg[0] <= pos[0];
            out_data_reg[1] <= pos[1];
            out_data_reg[2] <= pos[2];
            out_data_reg[3] <= pos[3];
            cnt_reg         <= 3'(acc_cnt_reg) + 3'd1;
            run_last_reg    <= byte_in.last;
            line_last_reg   <= byte_in.last && byte_in.eol;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte_a = out_data_reg[0];
    assign out_byte_b = out_data_reg[1];
    assign out_byte_c = out_data_reg[2];
    assign out_byte_d = out_data_reg[3];
    assign byte_count = cnt_reg;
    assign run_last   = run_last_reg;
    assign line_last  = line_last_reg;

endmodule

`default_nettype wire

// ===== src/raster_line_compressor.sv =====
// ----------------------------------------------------------------------------
// raster_line_compressor: one raster byte in, raw / rle / packbits bytes out
// an item is accepted in the idle state, then every byte it emits, the
// literal header included, goes out; no new item is taken until they have
// all moved. literal flushes read the literal store one byte per cycle while
// the packer is ready; a result is valid the cycle after its last byte
// moves, and output stalls hold it back
// reset: mode none, encoder idle; the literal store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module raster_line_compressor #(
    parameter int MAX_PACK_RUN = rlc_pkg::DEF_MAX_PACK_RUN,
    parameter int MAX_RLE_RUN  = rlc_pkg::DEF_MAX_RLE_RUN
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] compression_mode,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_line,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte_a,
    output logic [7:0]      out_byte_b,
    output logic [7:0]      out_byte_c,
    output logic [7:0]      out_byte_d,
    output logic [2:0]      byte_count,
    output logic            run_last,
    output logic            line_last
);

    import rlc_pkg::*;

    mode_t     compression_mode_reg;
    logic      enc_byte_valid;
    logic      enc_byte_ready;
    rlc_byte_t enc_byte;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compression_mode_reg <= MODE_NONE;
        end
        else if (cfg_wr_en)
        begin
            compression_mode_reg <= mode_t'(compression_mode);
        end
    end

    rlc_encoder #(
        .MAX_PACK_RUN (MAX_PACK_RUN),
        .MAX_RLE_RUN  (MAX_RLE_RUN)
    ) u_encoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (compression_mode_reg),
        .clear       (cfg_wr_en),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_line (end_of_line),
        .byte_valid  (enc_byte_valid),
        .byte_ready  (enc_byte_ready),
        .byte_out    (enc_byte)
    );

    rlc_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (enc_byte_valid),
        .byte_ready (enc_byte_ready),
        .byte_in    (enc_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte_a (out_byte_a),
        .out_byte_b (out_byte_b),
        .out_byte_c (out_byte_c),
        .out_byte_d (out_byte_d),
        .byte_count (byte_count),
        .run_last   (run_last),
        .line_last  (line_last)
    );

    // pass-through transfer puts its single closing byte out the next cycle
    `ASSERT_NEXT(a_raw_next_byte, clk, rst_n,
        in_valid && in_ready &&
        (compression_mode_reg == MODE_NONE || compression_mode_reg == MODE_RAW),
        enc_byte_valid && enc_byte.last, "pass-through item did not emit its byte")

    // byte lanes past the count are zero; lane d is checked here
    `ASSERT_IMPLY(a_lane_d_zero, clk, rst_n, out_valid && byte_count != 3'd4,
        out_byte_d == 8'd0, "unused lane d not zero")

    // end of line only on the closing result of an item
    `ASSERT_IMPLY(a_line_run_last, clk, rst_n, out_valid && line_last,
        run_last, "line_last without run_last")

endmodule

`default_nettype wire

// ===== verif/rlc_stream_checker.sv =====
// ----------------------------------------------------------------------------
// rlc_stream_checker
// watches the byte and result channels of the raster line compressor,
// encodes every accepted byte in the selected mode, packs the encoded
// stream into four-byte words and compares each result transfer with them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlc_stream_checker
    import rlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        compression_mode,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              end_of_line,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        out_byte_a,
    input  logic [7:0]        out_byte_b,
    input  logic [7:0]        out_byte_c,
    input  logic [7:0]        out_byte_d,
    input  logic [2:0]        byte_count,
    input  logic              run_last,
    input  logic              line_last,
    output int unsigned       error_count,
    output int unsigned       words_pending
);

    localparam int         PACK_RUN_MAX = DEF_MAX_PACK_RUN;
    localparam int         RLE_RUN_MAX  = DEF_MAX_RLE_RUN;
    localparam logic [8:0] REP_HDR_BIAS = 9'd257;
    localparam logic [7:0] LONE_HDR     = 8'h00;
    localparam int         WORD_BYTES   = 4;

    // one result word as it appears on the output channel
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [2:0] count;
        logic       run_end;
        logic       eol_mark;
    } comp_word_t;

    // encoder copy
    mode_t      mode_q;
    logic [7:0] held;
    logic [8:0] run_len;
    enc_phase_t phase;
    logic [7:0] lit_buf [0:127];
    int         lit_cnt;

    // encoded bytes of the current transfer and words still to arrive
    logic [7:0] stream [$];
    comp_word_t expected_words [$];

    function automatic void restart_encoder();
        held    = '0;
        run_len = '0;
        phase   = PH_IDLE;
        lit_cnt = 0;
    endfunction

    function automatic void emit(input logic [7:0] v);
        stream.push_back(v);
    endfunction

    function automatic logic [7:0] rep_header();
        logic [8:0] hdr;
        hdr = REP_HDR_BIAS - run_len;
        return hdr[7:0];
    endfunction

    // literal header then the buffered bytes
    function automatic void drain_literals();
        if (lit_cnt == 0)
            return;
        emit(8'(lit_cnt - 1));
        for (int i = 0; i < lit_cnt; i++)
            emit(lit_buf[i]);
        lit_cnt = 0;
    endfunction

    // held byte opens a sequence, b decides repeat or literal
    function automatic void pair_with_held(input logic [7:0] b);
        if (b == held) begin
            run_len = 9'd2;
            phase   = PH_REP;
        end
        else begin
            lit_buf[0] = held;
            lit_cnt    = 1;
            held       = b;
            phase      = PH_LIT;
        end
    endfunction

    function automatic void pack_byte(input logic [7:0] b);
        case (phase)
            PH_HELD: pair_with_held(b);
            PH_REP:
            begin
                if (b == held && run_len < PACK_RUN_MAX)
                    run_len++;
                else begin
                    emit(rep_header());
                    emit(held);
                    held  = b;
                    phase = PH_HELD;
                end
            end
            PH_LIT:
            begin
                if (b != held && lit_cnt < PACK_RUN_MAX) begin
                    lit_buf[lit_cnt] = held;
                    lit_cnt++;
                    held = b;
                end
                else begin
                    drain_literals();
                    pair_with_held(b);
                end
            end
            default:
            begin
                held  = b;
                phase = PH_HELD;
            end
        endcase
    endfunction

    // the last byte of a line never joins a literal
    function automatic void pack_line_end();
        case (phase)
            PH_REP:
            begin
                emit(rep_header());
                emit(held);
            end
            PH_LIT:
            begin
                drain_literals();
                emit(LONE_HDR);
                emit(held);
            end
            PH_HELD:
            begin
                emit(LONE_HDR);
                emit(held);
            end
            default: ;
        endcase
        restart_encoder();
    endfunction

    function automatic void rle_byte(input logic [7:0] b);
        if (phase == PH_REP) begin
            if (b == held && run_len < RLE_RUN_MAX) begin
                run_len++;
                return;
            end
            emit(8'(run_len - 1));
            emit(held);
        end
        held    = b;
        run_len = 9'd1;
        phase   = PH_REP;
    endfunction

    function automatic void rle_line_end();
        if (phase == PH_REP) begin
            emit(8'(run_len - 1));
            emit(held);
        end
        restart_encoder();
    endfunction

    // encode one byte and queue the words it produces
    function automatic void predict_words(input logic [7:0] b, input logic eol);
        int         n;
        comp_word_t w;
        stream.delete();
        case (mode_q)
            MODE_RLE:
            begin
                rle_byte(b);
                if (eol)
                    rle_line_end();
            end
            MODE_PACK:
            begin
                pack_byte(b);
                if (eol)
                    pack_line_end();
            end
            default: emit(b);
        endcase
        n = stream.size();
        for (int k = 0; k < n; k += WORD_BYTES) begin
            w   = '0;
            w.a = stream[k];
            if (k + 1 < n) w.b = stream[k + 1];
            if (k + 2 < n) w.c = stream[k + 2];
            if (k + 3 < n) w.d = stream[k + 3];
            w.count    = 3'((n - k > WORD_BYTES) ? WORD_BYTES : n - k);
            w.run_end  = (k + WORD_BYTES >= n);
            w.eol_mark = eol && w.run_end;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // follow register writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : track
        comp_word_t want;
        if (!rst_n) begin
            mode_q = MODE_NONE;
            restart_encoder();
            expected_words.delete();
            error_count = 0;
        end
        else begin
            // a register write restarts the encoder
            if (cfg_wr_en) begin
                mode_q = mode_t'(compression_mode);
                restart_encoder();
            end
            // result transfer
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result transfer with nothing expected: bytes %h %h %h %h count %0d",
                           out_byte_a, out_byte_b, out_byte_c, out_byte_d, byte_count);
                    error_count++;
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("out_byte_a", want.a, out_byte_a);
                    check_field("out_byte_b", want.b, out_byte_b);
                    check_field("out_byte_c", want.c, out_byte_c);
                    check_field("out_byte_d", want.d, out_byte_d);
                    check_field("byte_count", 8'(want.count), 8'(byte_count));
                    check_field("run_last", 8'(want.run_end), 8'(run_last));
                    check_field("line_last", 8'(want.eol_mark), 8'(line_last));
                end
            end
            // input transfer
            if (in_valid && in_ready)
                predict_words(data_byte, end_of_line);
        end
        words_pending = expected_words.size();
    end

endmodule

// ===== verif/raster_line_compressor_tb.sv =====
// ----------------------------------------------------------------------------
// raster_line_compressor_tb
// drives raster lines through all compression modes: a directed set of
// short lines for the edge cases, then random lines built from repeats,
// literal stretches and noise, one longest packbits literal among them,
// with bursty input, a stalling receiver and one long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_line_compressor_tb;

    import rlc_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  compression_mode = MODE_NONE;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte_a;
    logic [7:0]  out_byte_b;
    logic [7:0]  out_byte_c;
    logic [7:0]  out_byte_d;
    logic [2:0]  byte_count;
    logic        run_last;
    logic        line_last;
    int unsigned error_count;
    int unsigned words_pending;

    // sender and receiver pacing
    int          burst_left = 4;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    // bytes of the line being built
    logic [7:0]  line_bytes [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    raster_line_compressor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .compression_mode (compression_mode),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .end_of_line      (end_of_line),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte_a       (out_byte_a),
        .out_byte_b       (out_byte_b),
        .out_byte_c       (out_byte_c),
        .out_byte_d       (out_byte_d),
        .byte_count       (byte_count),
        .run_last         (run_last),
        .line_last        (line_last)
    );

    rlc_stream_checker u_checker (.*);

    function automatic void add_run(input int n, input logic [7:0] v);
        repeat (n) line_bytes.push_back(v);
    endfunction

    // each byte differs from the one before it
    function automatic void add_literal(input int n);
        logic [7:0] v;
        v = (line_bytes.size() != 0) ? line_bytes[$] : 8'($urandom);
        repeat (n) begin
            v = v + 8'($urandom_range(1, 255));
            line_bytes.push_back(v);
        end
    endfunction

    // mostly short lines of repeats, literal stretches and noise
    function automatic void build_line();
        int len;
        int n;
        int kind;
        line_bytes.delete();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        while (line_bytes.size() < len) begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, 8);
            if (n > len - line_bytes.size())
                n = len - line_bytes.size();
            if (kind < 4)
                add_run(n, 8'($urandom));
            else if (kind < 8)
                add_literal(n);
            else
                repeat (n) line_bytes.push_back(8'($urandom));
        end
    endfunction

    // send the built line in bursts, marking the last byte if the line closes
    task automatic feed_line(input bit close);
        int gap;
        for (int i = 0; i < line_bytes.size(); i++) begin
            in_valid    <= 1'b1;
            data_byte   <= line_bytes[i];
            end_of_line <= close && (i == line_bytes.size() - 1);
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    // stop sending and wait until every expected word has arrived
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (words_pending == 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        settle(SETTLE_CYCLES);
        cfg_wr_en        <= 1'b1;
        compression_mode <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        mode_t phase_mode [PHASES];
        int    phase_budget [PHASES];
        int    taken;

        phase_mode   = '{MODE_NONE, MODE_RLE, MODE_PACK, MODE_RAW, MODE_PACK, MODE_RLE};
        phase_budget = '{20, 20, 25, 10, 25, 15};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through of the byte extremes
        set_mode(MODE_NONE);
        line_bytes = '{8'h00, 8'hFF, 8'h5A};
        feed_line(1'b1);

        // rle: one-byte line, then a run ended by a different last byte
        set_mode(MODE_RLE);
        line_bytes = '{8'h00};
        feed_line(1'b1);
        line_bytes = '{8'h07, 8'h07, 8'h07, 8'hFF};
        feed_line(1'b1);

        // packbits: lone last byte
        set_mode(MODE_PACK);
        line_bytes = '{8'h80};
        feed_line(1'b1);
        // shortest repeat closing the line
        line_bytes = '{8'h03, 8'h03};
        feed_line(1'b1);
        // literal that must leave out the last byte
        line_bytes = '{8'h01, 8'h02, 8'h03};
        feed_line(1'b1);
        // repeat broken by a single last byte
        line_bytes = '{8'h09, 8'h09, 8'h09, 8'h04};
        feed_line(1'b1);
        // literal flushed by a following repeat
        line_bytes = '{8'h01, 8'h02, 8'h05, 8'h05, 8'h05};
        feed_line(1'b1);
        // part line left pending, dropped by the next mode write
        line_bytes = '{8'h11, 8'h22};
        feed_line(1'b0);

        // random phases over all modes
        for (int p = 0; p < PHASES; p++) begin
            set_mode(phase_mode[p]);
            if (p == 0)
                hold_req = 1'b1;
            // longest packbits literal, flushed while a new one starts
            if (p == 2) begin
                line_bytes.delete();
                add_literal(130);
                feed_line(1'b1);
            end
            taken = 0;
            while (taken < phase_budget[p]) begin
                build_line();
                taken += line_bytes.size();
                feed_line(!(taken >= phase_budget[p] && $urandom_range(0, 2) == 0));
            end
        end

        settle(END_CYCLES);
        if (error_count == 0 && words_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: stretches of steady, random and sparse stalls, one long hold-off
    initial
    begin : receiver
        int style;
        int stretch;
        forever begin
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(8, 64);
            repeat (stretch) begin
                @(posedge clk);
                if (hold_req && !hold_done) begin
                    out_ready <= 1'b0;
                    hold_done = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
